// ----- sv/fmop_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and constant tables of the FM operator.
// Used by fmop_env, fm_operator_with_envelope and tb_top; depends on nothing.
package fmop_pkg;

  // Fixed-point formats
  localparam int PHASE_W    = 24;  // phase accumulator, Q0.24 of one cycle
  localparam int SINE_IDX_W = 10;  // sine points per cycle, log2
  localparam int QTR_W      = SINE_IDX_W - 2;
  localparam int QSINE_N    = (1 << QTR_W) + 1;  // quarter wave, both end points
  localparam int ENV_FRAC   = 24;
  localparam int ENV_W      = ENV_FRAC + 1;      // envelope, 1.0 included
  localparam int MAG_W      = 15;
  localparam int AMP_W      = 17;
  localparam int STEP_W     = 25;
  localparam int LVL_W      = 7;
  localparam int NUM_STAGES = 4;
  localparam int LEVELS_W   = LVL_W * NUM_STAGES;
  localparam int LVL_N      = 1 << LVL_W;
  localparam int LVL_MAX    = 99;
  localparam int SAMPLE_W   = 16;
  localparam int PROD_A_W   = MAG_W + AMP_W;
  localparam int PROD_B_W   = PROD_A_W + ENV_W;
  localparam int ROUND_SH   = ENV_FRAC + 16;
  localparam int Q_W        = PROD_B_W + 1 - ROUND_SH;

  // Configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PHASE_INC   = 3'd0,
    REG_AMPLITUDE   = 3'd1,
    REG_STEP_ONE    = 3'd2,
    REG_STEP_TWO    = 3'd3,
    REG_STEP_THREE  = 3'd4,
    REG_STEP_REL    = 3'd5,
    REG_LEVELS      = 3'd6
  } reg_idx_t;

  // Operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_RESET    = 2'd3
  } op_t;

  // Envelope stages
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_ONE   = 3'd1,
    ST_TWO   = 3'd2,
    ST_THREE = 3'd3,
    ST_REL   = 3'd4
  } env_stage_t;

  // Control sequencer states of the top level
  typedef enum logic [2:0] {
    CS_IDLE,
    CS_ENV,
    CS_MUL_A,
    CS_MUL_B,
    CS_DONE
  } ctl_state_t;

  typedef struct packed {
    env_stage_t          stage;
    logic [ENV_W-1:0]    value;
  } env_state_t;

  // One voice state word as kept in the state memory
  typedef struct packed {
    logic [PHASE_W-1:0]  acc;
    env_state_t          env;
  } voice_t;

  typedef logic [NUM_STAGES-1:0][STEP_W-1:0] step_set_t;

  // Polynomial coefficients of sin(pi/2 x), Q30
  localparam logic [63:0] K1 = 64'd1686629713;
  localparam logic [63:0] K3 = 64'd693598668;
  localparam logic [63:0] K5 = 64'd85569306;
  localparam logic [63:0] K7 = 64'd5026995;
  localparam logic [63:0] K9 = 64'd172272;

  typedef logic [QSINE_N-1:0][MAG_W-1:0] qsine_tab_t;
  typedef logic [LVL_N-1:0][ENV_W-1:0]   level_tab_t;

  // Quarter-wave sine of x (Q30), result 0..32767
  function automatic logic [MAG_W-1:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] v;
    x2 = (x * x) >> 30;
    p  = K9;
    p  = K7 - ((x2 * p) >> 30);
    p  = K5 - ((x2 * p) >> 30);
    p  = K3 - ((x2 * p) >> 30);
    p  = K1 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    return (v > 64'd32767) ? MAG_W'(32767) : v[MAG_W-1:0];
  endfunction

  function automatic qsine_tab_t build_qsine();
    qsine_tab_t t;
    for (int i = 0; i < QSINE_N; i++) begin
      t[i] = quarter_sine(64'(i) << (32 - SINE_IDX_W));
    end
    return t;
  endfunction

  // Level code to envelope target, codes above the maximum saturate
  function automatic level_tab_t build_levels();
    level_tab_t t;
    logic [63:0] lv;
    for (int i = 0; i < LVL_N; i++) begin
      lv   = (i > LVL_MAX) ? 64'(LVL_MAX) : 64'(i);
      t[i] = ENV_W'(((lv << ENV_FRAC) + 64'd49) / 64'd99);
    end
    return t;
  endfunction

  localparam qsine_tab_t QSINE     = build_qsine();
  localparam level_tab_t LEVEL_TAB = build_levels();

endpackage

// ----- sv/fmop_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
module fmop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/fmop_env.sv -----
`timescale 1ns / 1ps
// One step of the four-stage linear envelope toward its stage target.
// Depends on fmop_pkg for stage codes, level table and state types.
module fmop_env
  import fmop_pkg::*;
(
  input  env_state_t            cur,
  input  step_set_t             steps,
  input  logic [LEVELS_W-1:0]   levels,
  output env_state_t            nxt
);

  logic                stepping;
  logic [1:0]          k;
  logic [LVL_W-1:0]    lv;
  logic [ENV_W-1:0]    target;
  logic [STEP_W-1:0]   step;
  logic [ENV_W-1:0]    diff;
  logic                rising;

  // Select target and step of the current stage
  always_comb begin
    stepping = (cur.stage == ST_ONE) || (cur.stage == ST_TWO) ||
               (cur.stage == ST_THREE) || (cur.stage == ST_REL);
    k        = 2'(cur.stage - ST_ONE);
    lv       = levels[k*LVL_W +: LVL_W];
    target   = LEVEL_TAB[lv];
    step     = (steps[k] == '0) ? STEP_W'(1) : steps[k];
    rising   = (target >= cur.value);
    diff     = rising ? (target - cur.value) : (cur.value - target);
  end

  // Advance the value; within one step snap to target and end stage 1 or 2
  always_comb begin
    nxt = cur;
    if (stepping) begin
      if (diff <= step) begin
        nxt.value = target;
        unique case (cur.stage)
          ST_ONE:  nxt.stage = ST_TWO;
          ST_TWO:  nxt.stage = ST_THREE;
          ST_REL:  nxt.stage = (target == '0) ? ST_IDLE : ST_REL;
          default: nxt.stage = cur.stage;
        endcase
      end else if (rising) begin
        nxt.value = cur.value + step;
      end else begin
        nxt.value = cur.value - step;
      end
    end
  end

endmodule

// ----- sv/fm_operator_with_envelope.sv -----
`timescale 1ns / 1ps
// FM operator with four-stage envelope: top level, APB registers and control.
// Transactions are handled one at a time: after acceptance the state is read, then come the envelope step and
// sine lookup, the two products, and rounding into the output register, which waits while a result is unread.
// Voice state lives in a RAM with registered read data, read on acceptance and written back at the end.
// Reset (synchronous): control idle, registers to defaults, voice state reads as zero/idle.
// Depends on fmop_pkg, fmop_ram and fmop_env.
module fm_operator_with_envelope
  import fmop_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [APB_AW-1:0]           paddr,
  input  logic [APB_DW-1:0]           pwdata,
  output logic [APB_DW-1:0]           prdata,
  output logic                        pready,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  op,
  input  logic signed [27:0]          phase_mod,
  // Output channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  sample,
  output logic [ENV_W-1:0]            eg_level,
  output logic                        active
);

  localparam logic [0:0] STATE_ADDR = 1'b0;

  // Configuration registers
  logic [PHASE_W-1:0]   phase_increment;
  logic [AMP_W-1:0]     amplitude;
  step_set_t            steps;
  logic [LEVELS_W-1:0]  stage_levels;

  // Control
  ctl_state_t  cs, cs_next;
  logic        in_fire, done_fire, state_valid;

  // Datapath registers
  logic [1:0]              op_q;
  logic [PHASE_W-1:0]      mod_q;
  voice_t                  voice_new;
  logic [ENV_W-1:0]        env_mul;
  logic [MAG_W-1:0]        mag_q;
  logic                    neg_q;
  logic [PROD_A_W-1:0]     prod_a;
  logic [PROD_B_W-1:0]     prod_b;

  // Combinational
  logic [$bits(voice_t)-1:0] ram_q;
  voice_t                  voice_cur;
  env_state_t              env_step;
  voice_t                  voice_calc;
  logic [PHASE_W-1:0]      ph;
  logic [SINE_IDX_W-1:0]   sidx;
  logic [QTR_W:0]          pos;
  logic [MAG_W-1:0]        mag_calc;
  logic                    neg_calc;
  logic [PROD_B_W:0]       rsum;
  logic [Q_W-1:0]          q;
  logic [SAMPLE_W-1:0]     sample_calc;
  logic                    cfg_we;

  // APB write and readback
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= '0;
      amplitude       <= AMP_W'(65536);
      steps           <= {NUM_STAGES{STEP_W'(1297)}};
      stage_levels    <= LEVELS_W'(1634787);
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_PHASE_INC:  phase_increment <= pwdata[PHASE_W-1:0];
        REG_AMPLITUDE:  amplitude       <= pwdata[AMP_W-1:0];
        REG_STEP_ONE:   steps[0]        <= pwdata[STEP_W-1:0];
        REG_STEP_TWO:   steps[1]        <= pwdata[STEP_W-1:0];
        REG_STEP_THREE: steps[2]        <= pwdata[STEP_W-1:0];
        REG_STEP_REL:   steps[3]        <= pwdata[STEP_W-1:0];
        REG_LEVELS:     stage_levels    <= pwdata[LEVELS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_PHASE_INC:  prdata = APB_DW'(phase_increment);
      REG_AMPLITUDE:  prdata = APB_DW'(amplitude);
      REG_STEP_ONE:   prdata = APB_DW'(steps[0]);
      REG_STEP_TWO:   prdata = APB_DW'(steps[1]);
      REG_STEP_THREE: prdata = APB_DW'(steps[2]);
      REG_STEP_REL:   prdata = APB_DW'(steps[3]);
      REG_LEVELS:     prdata = APB_DW'(stage_levels);
      default:        prdata = '0;
    endcase
  end

  // Voice state memory
  fmop_ram #(
    .WIDTH ($bits(voice_t)),
    .DEPTH (2)
  ) u_state_ram (
    .clk   (clk),
    .we    (done_fire),
    .waddr (STATE_ADDR),
    .wdata (voice_new),
    .re    (in_fire),
    .raddr (STATE_ADDR),
    .rdata (ram_q)
  );

  // Hold reset values until the first write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      state_valid <= 1'b0;
    end else if (done_fire) begin
      state_valid <= 1'b1;
    end
  end

  assign voice_cur = state_valid ? voice_t'(ram_q) : '0;

  // Control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      cs <= CS_IDLE;
    end else begin
      cs <= cs_next;
    end
  end

  always_comb begin
    cs_next   = cs;
    in_ready  = 1'b0;
    done_fire = 1'b0;
    unique case (cs)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cs_next = CS_ENV;
      end
      CS_ENV:   cs_next = CS_MUL_A;
      CS_MUL_A: cs_next = CS_MUL_B;
      CS_MUL_B: cs_next = CS_DONE;
      CS_DONE: begin
        if (!out_valid || out_ready) begin
          done_fire = 1'b1;
          cs_next   = CS_IDLE;
        end
      end
      default: cs_next = CS_IDLE;
    endcase
  end

  assign in_fire = in_valid && in_ready;

  // Envelope step
  fmop_env u_env (
    .cur    (voice_cur.env),
    .steps  (steps),
    .levels (stage_levels),
    .nxt    (env_step)
  );

  // Sine lookup of phase plus modulation, mirrored by quadrant
  always_comb begin
    ph   = voice_cur.acc + mod_q;
    sidx = ph[PHASE_W-1 -: SINE_IDX_W];
    pos  = sidx[QTR_W] ? ((QTR_W+1)'(1) << QTR_W) - {1'b0, sidx[QTR_W-1:0]}
                       : {1'b0, sidx[QTR_W-1:0]};
  end

  // Apply the operation to the voice state
  always_comb begin
    voice_calc = voice_cur;
    mag_calc   = '0;
    neg_calc   = 1'b0;
    case (op_q)
      OP_SAMPLE: begin
        voice_calc.env = env_step;
        voice_calc.acc = voice_cur.acc + phase_increment;
        mag_calc       = QSINE[pos];
        neg_calc       = sidx[SINE_IDX_W-1];
      end
      OP_NOTE_ON:  voice_calc.env.stage = ST_ONE;
      OP_NOTE_OFF: voice_calc.env.stage = ST_REL;
      default:     voice_calc = '0;
    endcase
  end

  // Latch the transaction, then run the two products
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q  <= op;
      mod_q <= phase_mod[PHASE_W-1:0];
    end
    if (cs == CS_ENV) begin
      voice_new <= voice_calc;
      env_mul   <= (voice_calc.env.stage == ST_IDLE) ? '0 : voice_calc.env.value;
      mag_q     <= mag_calc;
      neg_q     <= neg_calc;
    end
    if (cs == CS_MUL_A) begin
      prod_a <= PROD_A_W'(mag_q) * PROD_A_W'(amplitude);
    end
    if (cs == CS_MUL_B) begin
      prod_b <= PROD_B_W'(prod_a) * PROD_B_W'(env_mul);
    end
  end

  // Round to nearest and saturate
  always_comb begin
    rsum = {1'b0, prod_b} + ((PROD_B_W+1)'(1) << (ROUND_SH - 1));
    q    = rsum[PROD_B_W -: Q_W];
    if (neg_q) begin
      sample_calc = (q > Q_W'(32768)) ? 16'h8000 : SAMPLE_W'(Q_W'(0) - q);
    end else begin
      sample_calc = (q > Q_W'(32767)) ? 16'h7FFF : q[SAMPLE_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      sample   <= sample_calc;
      eg_level <= voice_new.env.value;
      active   <= (voice_new.env.stage != ST_IDLE);
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of fm_operator_with_envelope: directed cases, then random notes.
// Depends on fmop_pkg for port widths, operation codes, register indexes and stages.
module tb_top
  import fmop_pkg::*;
;

  localparam int HALF_PERIOD_NS = 10;
  localparam int TIMEOUT_NS     = 10_000_000;
  localparam int MAX_PRINTED    = 40;

  // Receiver stall patterns
  localparam int READY_ALWAYS  = 0;
  localparam int READY_RANDOM  = 1;
  localparam int READY_PATTERN = 2;

  // Sine polynomial coefficients, Q30, lowest order first
  localparam logic [63:0] SINE_COEF [5] = '{64'd1686629713, 64'd693598668, 64'd85569306,
                                            64'd5026995, 64'd172272};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [ENV_W-1:0]           level;
    logic                       act;
  } tone_t;

  // DUT signals
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [APB_AW-1:0]          paddr = '0;
  logic [APB_DW-1:0]          pwdata = '0;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 op = OP_SAMPLE;
  logic signed [27:0]         phase_mod = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic [ENV_W-1:0]           eg_level;
  logic                       active;

  // Predictor copy of the registers and the voice state
  logic [23:0]       cfg_inc    = '0;
  logic [16:0]       cfg_amp    = 17'd65536;
  logic [24:0]       cfg_step [4] = '{25'd1297, 25'd1297, 25'd1297, 25'd1297};
  logic [27:0]       cfg_levels = 28'd1634787;
  logic [23:0]       v_phase    = '0;
  env_stage_t        v_stage    = ST_IDLE;
  logic [ENV_W-1:0]  v_env      = '0;

  tone_t expected_tones [$];

  int mismatches      = 0;
  int results_checked = 0;
  int sent_count      = 0;
  int directed_count  = 0;
  int settings_count  = 0;
  int burst_left      = 0;
  int gap_max         = 0;
  int stall_mode      = READY_ALWAYS;
  int hold_left       = 0;
  int ready_phase     = 0;

  fm_operator_with_envelope uut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .phase_mod (phase_mod),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample),
    .eg_level  (eg_level),
    .active    (active)
  );

  always #(HALF_PERIOD_NS) clk = ~clk;

  // Print one line per mismatch (capped) and count all of them
  task automatic flag_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic logic [ENV_W-1:0] target_of(input int k);
    logic [63:0] code;
    code = 64'((cfg_levels >> (LVL_W * k)) & 28'h7F);
    if (code > 64'd99) code = 64'd99;
    return ENV_W'(((code << 24) + 64'd49) / 64'd99);
  endfunction

  // Quarter wave of sin(pi/2 x), x in Q30, evaluated by Horner's rule
  function automatic logic [14:0] quarter_wave(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] v;
    x2  = (x * x) >> 30;
    acc = SINE_COEF[4];
    for (int i = 3; i >= 0; i--) begin
      acc = SINE_COEF[i] - ((x2 * acc) >> 30);
    end
    v = ((((x * acc) >> 30) * 64'd32767) + (64'd1 << 29)) >> 30;
    return (v > 64'd32767) ? 15'd32767 : v[14:0];
  endfunction

  function automatic int sine_at(input logic [9:0] idx);
    logic [1:0]  quad;
    logic [8:0]  pos;
    logic [14:0] m;
    quad = idx[9:8];
    pos  = quad[0] ? (9'd256 - {1'b0, idx[7:0]}) : {1'b0, idx[7:0]};
    m    = quarter_wave(64'(pos) << 22);
    return quad[1] ? -int'(m) : int'(m);
  endfunction

  // Move the envelope one step toward the target of its stage
  task automatic step_envelope();
    int               k;
    logic [ENV_W-1:0] tgt;
    logic [ENV_W-1:0] stp;
    logic [ENV_W-1:0] diff;
    if (v_stage == ST_IDLE || v_stage > ST_REL) return;
    k    = int'(v_stage) - 1;
    tgt  = target_of(k);
    stp  = (cfg_step[k] == '0) ? ENV_W'(1) : cfg_step[k];
    diff = (tgt >= v_env) ? (tgt - v_env) : (v_env - tgt);
    if (diff <= stp) begin
      v_env = tgt;
      case (v_stage)
        ST_ONE: v_stage = ST_TWO;
        ST_TWO: v_stage = ST_THREE;
        ST_REL: if (tgt == '0) v_stage = ST_IDLE;
        default: ;
      endcase
    end else if (tgt > v_env) begin
      v_env = v_env + stp;
    end else begin
      v_env = v_env - stp;
    end
  endtask

  task automatic predict_operator(input op_t code, input logic [27:0] pm, output tone_t t);
    logic [ENV_W-1:0] env;
    logic [23:0]      ph;
    int               s;
    int               smp;
    logic [63:0]      mag;
    logic [63:0]      q;
    smp = 0;
    case (code)
      OP_SAMPLE: begin
        step_envelope();
        env = (v_stage == ST_IDLE) ? '0 : v_env;
        ph  = v_phase + pm[23:0];
        s   = sine_at(ph[23:14]);
        mag = 64'((s < 0) ? -s : s);
        q   = ((mag * 64'(env) * 64'(cfg_amp)) + (64'd1 << 39)) >> 40;
        if (s < 0) smp = (q > 64'd32768) ? -32768 : -int'(q);
        else smp = (q > 64'd32767) ? 32767 : int'(q);
        v_phase = v_phase + cfg_inc;
      end
      OP_NOTE_ON:  v_stage = ST_ONE;
      OP_NOTE_OFF: v_stage = ST_REL;
      default: begin
        v_phase = '0;
        v_stage = ST_IDLE;
        v_env   = '0;
      end
    endcase
    t.sample = SAMPLE_W'(smp);
    t.level  = v_env;
    t.act    = (v_stage != ST_IDLE);
  endtask

  // ---------------------------------------------------------------- drivers

  // Send one transaction; open a new burst after a random gap when the last one ran out
  task automatic offer_item(input op_t code, input logic [27:0] pm);
    tone_t t;
    int    gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    op        <= code;
    phase_mod <= pm;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_operator(code, pm, t);
    expected_tones.push_back(t);
    sent_count++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_tones.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_cycle(input logic wr, input reg_idx_t r, input logic [31:0] wd,
                           output logic [31:0] rd);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_AW'(4 * int'(r));
    pwdata  <= wd;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [31:0] reg_mask(input reg_idx_t r);
    case (r)
      REG_PHASE_INC: return 32'h00FF_FFFF;
      REG_AMPLITUDE: return 32'h0001_FFFF;
      REG_LEVELS:    return 32'h0FFF_FFFF;
      default:       return 32'h01FF_FFFF;
    endcase
  endfunction

  // Write a register, read it back, and mirror it in the predictor
  task automatic program_register(input reg_idx_t r, input logic [31:0] val);
    logic [31:0] rd;
    logic [31:0] want;
    want = val & reg_mask(r);
    apb_cycle(1'b1, r, val, rd);
    apb_cycle(1'b0, r, '0, rd);
    if (rd !== want)
      flag_mismatch($sformatf("register %s read back 0x%0h, wrote 0x%0h", r.name(), rd, want));
    case (r)
      REG_PHASE_INC:  cfg_inc     = want[23:0];
      REG_AMPLITUDE:  cfg_amp     = want[16:0];
      REG_STEP_ONE:   cfg_step[0] = want[24:0];
      REG_STEP_TWO:   cfg_step[1] = want[24:0];
      REG_STEP_THREE: cfg_step[2] = want[24:0];
      REG_STEP_REL:   cfg_step[3] = want[24:0];
      default:        cfg_levels  = want[27:0];
    endcase
  endtask

  task automatic apply_settings(input logic [31:0] inc, input logic [31:0] amp,
                                input logic [31:0] s1, input logic [31:0] s2,
                                input logic [31:0] s3, input logic [31:0] sr,
                                input logic [31:0] lv);
    program_register(REG_PHASE_INC, inc);
    program_register(REG_AMPLITUDE, amp);
    program_register(REG_STEP_ONE, s1);
    program_register(REG_STEP_TWO, s2);
    program_register(REG_STEP_THREE, s3);
    program_register(REG_STEP_REL, sr);
    program_register(REG_LEVELS, lv);
    settings_count++;
  endtask

  function automatic logic [31:0] pack_levels(input int a, input int b, input int c, input int d);
    return {4'd0, 7'(d), 7'(c), 7'(b), 7'(a)};
  endfunction

  function automatic logic [27:0] random_mod();
    case ($urandom_range(0, 9))
      0:       return 28'h0000000;
      1:       return 28'h7FFFFFF;
      2:       return 28'h8000000;
      default: return 28'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_step();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'd16777216;
      2:       return $urandom_range(1, 4096);
      default: return $urandom_range(1 << 18, 1 << 22);
    endcase
  endfunction

  // Mostly full notes (on, attack/decay samples, off, release samples), some stray transactions
  task automatic play_random_notes(input int n);
    int done;
    int k;
    done = 0;
    while (done < n) begin
      if ($urandom_range(0, 99) < 85) begin
        offer_item(OP_NOTE_ON, random_mod());
        k = $urandom_range(1, 40);
        repeat (k) offer_item(OP_SAMPLE, random_mod());
        offer_item(OP_NOTE_OFF, random_mod());
        done += k + 2;
        k = $urandom_range(1, 40);
        repeat (k) offer_item(OP_SAMPLE, random_mod());
        done += k;
        if ($urandom_range(0, 9) == 0) begin
          offer_item(OP_RESET, random_mod());
          done++;
        end
      end else begin
        offer_item(op_t'($urandom_range(0, 3)), random_mod());
        done++;
      end
    end
  endtask

  // ---------------------------------------------------------------- receiver and checker

  // Drive ready: a long hold when requested, else the current stall pattern
  always @(negedge clk) begin
    ready_phase = ready_phase + 1;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        READY_RANDOM:  out_ready <= ($urandom_range(0, 9) >= 3);
        READY_PATTERN: out_ready <= ((ready_phase % 13) >= 5);
        default:       out_ready <= 1'b1;
      endcase
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    tone_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_tones.size() == 0) begin
        flag_mismatch($sformatf("unexpected result sample %0d eg_level %0d active %0b",
                                sample, eg_level, active));
      end else begin
        want = expected_tones.pop_front();
        if (sample !== want.sample || eg_level !== want.level || active !== want.act)
          flag_mismatch($sformatf("result %0d: sample %0d want %0d, eg_level %0d want %0d, active %0b want %0b",
                                  results_checked, sample, want.sample, eg_level, want.level,
                                  active, want.act));
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Reset values of the registers; idle output, modulation extremes, every operation
  task automatic test_reset_defaults();
    stall_mode = READY_RANDOM;
    gap_max    = 2;
    offer_item(OP_SAMPLE, 28'h0000000);
    offer_item(OP_NOTE_ON, 28'h0000000);
    offer_item(OP_SAMPLE, 28'h0000000);
    offer_item(OP_SAMPLE, 28'h7FFFFFF);
    offer_item(OP_SAMPLE, 28'h8000000);
    offer_item(OP_NOTE_OFF, 28'h0000000);
    offer_item(OP_SAMPLE, 28'h0400000);
    offer_item(OP_RESET, 28'h0000000);
    offer_item(OP_SAMPLE, 28'h0C00000);
    directed_count += 9;
  endtask

  // Largest phase increment and amplitude: full-scale envelope, saturation both ways, level codes above 99
  task automatic test_full_scale();
    wait_drained();
    apply_settings(32'hFFFFFF, 32'h1FFFF, 32'd16777216, 32'd16777216, 32'd16777216,
                   32'd16777216, pack_levels(99, 127, 99, 0));
    stall_mode = READY_PATTERN;
    offer_item(OP_NOTE_ON, 28'h0000000);
    offer_item(OP_SAMPLE, 28'h0400000);
    offer_item(OP_SAMPLE, 28'h0C00000);
    offer_item(OP_SAMPLE, random_mod());
    offer_item(OP_NOTE_OFF, 28'h7FFFFFF);
    offer_item(OP_SAMPLE, 28'h0400000);
    offer_item(OP_SAMPLE, 28'h0400000);
    directed_count += 7;
  endtask

  // Zero steps count as one; release to a nonzero level stays active; zero amplitude
  task automatic test_slow_envelope();
    wait_drained();
    apply_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd16777216, pack_levels(50, 0, 0, 50));
    stall_mode = READY_ALWAYS;
    offer_item(OP_NOTE_ON, 28'h0000000);
    offer_item(OP_SAMPLE, 28'h0400000);
    offer_item(OP_SAMPLE, 28'h0400000);
    offer_item(OP_NOTE_OFF, 28'h0000000);
    offer_item(OP_SAMPLE, 28'h0400000);
    offer_item(OP_SAMPLE, 28'h0400000);
    offer_item(OP_RESET, 28'h0000000);
    offer_item(OP_SAMPLE, 28'h0400000);
    directed_count += 8;
  endtask

  // Random notes over six register settings: a smallest and a large one, then random ones
  task automatic test_random_settings();
    logic [31:0] lv;
    int          r;
    int          code;
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      if (ph == 0) begin
        apply_settings(32'd0, 32'd0, 32'd1, 32'd1, 32'd1, 32'd1, 32'd0);
      end else if (ph == 1) begin
        apply_settings(32'hFFFFFF, 32'd65536, 32'd16777216, 32'd16777216, 32'd16777216,
                       32'd16777216, pack_levels(99, 99, 99, 0));
      end else begin
        lv = '0;
        for (int s = 0; s < 4; s++) begin
          r    = $urandom_range(0, 9);
          code = (r < 2) ? $urandom_range(100, 127) : $urandom_range(0, 99);
          if (s == 3 && r < 7) code = 0;
          lv[LVL_W*s +: LVL_W] = 7'(code);
        end
        apply_settings($urandom_range(0, 24'hFFFFFF),
                       ($urandom_range(0, 9) == 0) ? 32'h1FFFF : $urandom_range(0, 65536),
                       random_step(), random_step(), random_step(), random_step(), lv);
      end
      stall_mode = ph % 3;
      gap_max    = (ph == 3) ? 0 : $urandom_range(1, 8);
      play_random_notes(150);
    end
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    wait_drained();
    apply_settings($urandom, 32'd65536, 32'd1 << 21, 32'd1 << 20, 32'd1 << 20, 32'd1 << 21,
                   pack_levels(99, 60, 40, 0));
    stall_mode = READY_ALWAYS;
    gap_max    = 0;
    hold_left  = 300;
    play_random_notes(60);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_full_scale();
    test_slow_envelope();
    test_random_settings();
    test_backpressure();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d operator transactions (%0d directed) over %0d register settings",
             sent_count, directed_count, settings_count);
    $display("Checked %0d results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: end a hung run
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still expected", expected_tones.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
